>>> sv/jlahd_pkg.sv
// Shared types, marker codes and sizes for the JPEG long AC code detector.
// No dependencies; every other file imports this package.
package jlahd_pkg;

  localparam int OFFSET_BITS_DEF = 20;
  localparam int SCAN_LIMIT_W    = 20;
  localparam int MAX_BITS_W      = 5;
  localparam int CFG_DATA_W      = 20;
  localparam int CFG_IDX_W       = 1;
  localparam int IN_Q_DEPTH      = 4;
  localparam int RES_Q_DEPTH     = 2;
  localparam int OUTCOME_W       = 3;

  localparam logic [SCAN_LIMIT_W-1:0] SCAN_LIMIT_RST = SCAN_LIMIT_W'(256 * 1024);
  localparam logic [MAX_BITS_W-1:0]   MAX_BITS_RST   = MAX_BITS_W'(10);

  localparam logic [7:0] MRK_PREFIX = 8'hFF;
  localparam logic [7:0] MRK_SOI    = 8'hD8;
  localparam logic [7:0] MRK_SOS    = 8'hDA;
  localparam logic [7:0] MRK_EOI    = 8'hD9;
  localparam logic [7:0] MRK_DHT    = 8'hC4;
  localparam logic [7:0] MRK_TEM    = 8'h01;
  localparam logic [7:0] MRK_RST0   = 8'hD0;
  localparam logic [7:0] MRK_RST7   = 8'hD7;

  localparam int          DHT_AC_BIT   = 4;
  localparam logic [3:0]  COUNT_LAST   = 4'd15;
  localparam logic [15:0] DHT_COUNTS   = 16'd16;
  localparam logic [15:0] LEN_MIN      = 16'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCAN_LIMIT    = 1'b0,
    CFG_MAX_CODE_BITS = 1'b1
  } cfg_idx_t;

  typedef enum logic [OUTCOME_W-1:0] {
    OUT_LONG_CODE  = 3'd0,
    OUT_STOP       = 3'd1,
    OUT_BAD_SOI    = 3'd2,
    OUT_BAD_LENGTH = 3'd3,
    OUT_BAD_DHT    = 3'd4,
    OUT_DATA_ENDED = 3'd5,
    OUT_LIMIT      = 3'd6
  } outcome_t;

  typedef enum logic [3:0] {
    PH_WAIT      = 4'd0,
    PH_SOI1      = 4'd1,
    PH_SOI2      = 4'd2,
    PH_PREFIX    = 4'd3,
    PH_MARKER    = 4'd4,
    PH_LEN_HI    = 4'd5,
    PH_LEN_LO    = 4'd6,
    PH_SKIP      = 4'd7,
    PH_DHT_INFO  = 4'd8,
    PH_DHT_COUNT = 4'd9,
    PH_DHT_SYM   = 4'd10,
    PH_DONE      = 4'd11
  } phase_t;

  typedef struct packed {
    logic is_ff;
    logic is_stop;
    logic is_nolen;
    logic is_dht;
  } byte_class_t;

  typedef struct packed {
    logic [7:0]  data;
    logic        first;
    logic        last;
    byte_class_t cls;
  } byte_item_t;

endpackage

>>> sv/jlahd_front.sv
// Front end: classifies each incoming byte and holds it in a short queue.
// Depends on jlahd_pkg.
module jlahd_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  logic [7:0]           data_byte,
  input  logic                 first_byte,
  input  logic                 last_byte,
  output logic                 full,
  input  logic                 q_pop,
  output logic                 q_valid,
  output jlahd_pkg::byte_item_t q_item
);
  import jlahd_pkg::*;

  localparam int PTR_W = $clog2(IN_Q_DEPTH);
  localparam int CNT_W = $clog2(IN_Q_DEPTH + 1);

  byte_item_t           mem_r [IN_Q_DEPTH];
  logic [PTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  byte_item_t           item_in;
  logic                 do_push, do_pop;

  always_comb begin
    item_in.data         = data_byte;
    item_in.first        = first_byte;
    item_in.last         = last_byte;
    item_in.cls.is_ff    = (data_byte == MRK_PREFIX);
    item_in.cls.is_stop  = (data_byte inside {MRK_SOS, MRK_EOI});
    item_in.cls.is_nolen = (data_byte inside {MRK_TEM, [MRK_RST0:MRK_RST7]});
    item_in.cls.is_dht   = (data_byte == MRK_DHT);
  end

  assign full    = (cnt_r == CNT_W'(IN_Q_DEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_item  = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = q_pop && q_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + CNT_W'(do_push) - CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= item_in;
    end
  end

endmodule

>>> sv/jlahd_back.sv
// Back end: marker segment walker and DHT length-count checker, one byte a cycle
// while res_full is low. Holds the configuration registers. Depends on jlahd_pkg.
module jlahd_back #(
  parameter int OFFSET_BITS = jlahd_pkg::OFFSET_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [jlahd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [jlahd_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                                 q_valid,
  input  jlahd_pkg::byte_item_t                q_item,
  output logic                                 q_pop,
  input  logic                                 res_full,
  output logic                                 res_push,
  output logic                                 res_long,
  output logic [jlahd_pkg::OUTCOME_W-1:0]      res_outcome,
  output logic [OFFSET_BITS-1:0]               res_offset
);
  import jlahd_pkg::*;

  localparam int CMP_W = (OFFSET_BITS > SCAN_LIMIT_W) ? OFFSET_BITS : SCAN_LIMIT_W;
  localparam logic [OFFSET_BITS-1:0] OFF_MAX = '1;

  logic [SCAN_LIMIT_W-1:0] scan_limit_r;
  logic [MAX_BITS_W-1:0]   max_bits_r;

  phase_t                  phase_r, phase_nxt;
  logic [OFFSET_BITS-1:0]  pos_r, pos_nxt;
  logic [OFFSET_BITS-1:0]  seg_r, seg_nxt;
  logic [15:0]             pr_r, pr_nxt;
  logic [7:0]              lh_r, lh_nxt;
  logic                    mk_dht_r, mk_dht_nxt;
  logic                    ac_r, ac_nxt;
  logic [3:0]              ci_r, ci_nxt;
  logic [11:0]             st_r, st_nxt;
  logic                    long_r, long_nxt;
  logic [11:0]             sk_r, sk_nxt;

  logic                    fire, active;
  phase_t                  ph;
  logic [OFFSET_BITS-1:0]  off, off_inc, seg_base;
  logic [15:0]             pr_cur, pr_dec, len, len_m2;
  logic [11:0]             st_new, sk_dec;
  logic                    long_new, lim_cur, lim_seg, len_bad, st_over;
  logic                    dec, seg_done;
  outcome_t                code;
  byte_item_t              it;

  assign it    = q_item;
  assign fire  = q_valid && !res_full;
  assign q_pop = fire;
  assign ph    = it.first ? PH_SOI1 : phase_r;
  assign active = fire && (ph != PH_WAIT) && (ph != PH_DONE);

  always_comb begin
    off      = it.first ? '0 : pos_r;
    off_inc  = (off == OFF_MAX) ? off : off + OFFSET_BITS'(1);
    seg_base = it.first ? '0 : seg_r;
    pr_cur   = it.first ? '0 : pr_r;
    pr_dec   = (pr_cur != '0) ? pr_cur - 16'd1 : pr_cur;
    len      = {lh_r, it.data};
    len_m2   = len - LEN_MIN;
    len_bad  = (len < LEN_MIN);
    st_new   = st_r + 12'(it.data);
    st_over  = ({4'b0, st_new} > pr_dec);
    long_new = long_r || (ac_r && (it.data != 8'd0) && ({1'b0, ci_r} >= max_bits_r));
    sk_dec   = (sk_r != '0) ? sk_r - 12'd1 : sk_r;
    lim_cur  = (CMP_W'(seg_base) >= CMP_W'(scan_limit_r));
    lim_seg  = (CMP_W'(off_inc) >= CMP_W'(scan_limit_r));
  end

  // next phase and decision
  always_comb begin
    phase_nxt = phase_r;
    dec       = 1'b0;
    code      = OUT_STOP;
    seg_done  = 1'b0;
    if (active) begin
      phase_nxt = ph;
      case (ph)
        PH_SOI1: begin
          if (!it.cls.is_ff) begin
            dec  = 1'b1;
            code = OUT_BAD_SOI;
          end else begin
            phase_nxt = PH_SOI2;
          end
        end
        PH_SOI2: begin
          if (it.data != MRK_SOI) begin
            dec  = 1'b1;
            code = OUT_BAD_SOI;
          end else begin
            phase_nxt = PH_PREFIX;
            dec       = lim_cur;
            code      = OUT_LIMIT;
          end
        end
        PH_PREFIX: begin
          if (it.cls.is_ff) begin
            phase_nxt = PH_MARKER;
          end else begin
            dec  = lim_cur;
            code = OUT_LIMIT;
          end
        end
        PH_MARKER: begin
          if (it.cls.is_ff) begin
            phase_nxt = PH_MARKER;
          end else if (it.cls.is_stop) begin
            dec  = 1'b1;
            code = OUT_STOP;
          end else if (it.cls.is_nolen) begin
            phase_nxt = PH_PREFIX;
            dec       = lim_cur;
            code      = OUT_LIMIT;
          end else begin
            phase_nxt = PH_LEN_HI;
          end
        end
        PH_LEN_HI: phase_nxt = PH_LEN_LO;
        PH_LEN_LO: begin
          if (len_bad) begin
            dec  = 1'b1;
            code = OUT_BAD_LENGTH;
          end else if (len_m2 == '0) begin
            seg_done  = 1'b1;
            phase_nxt = PH_PREFIX;
            dec       = lim_seg;
            code      = OUT_LIMIT;
          end else begin
            phase_nxt = mk_dht_r ? PH_DHT_INFO : PH_SKIP;
          end
        end
        PH_SKIP: begin
          if (pr_dec == '0) begin
            seg_done  = 1'b1;
            phase_nxt = PH_PREFIX;
            dec       = lim_seg;
            code      = OUT_LIMIT;
          end
        end
        PH_DHT_INFO: begin
          if (pr_dec < DHT_COUNTS) begin
            dec  = 1'b1;
            code = OUT_BAD_DHT;
          end else begin
            phase_nxt = PH_DHT_COUNT;
          end
        end
        PH_DHT_COUNT: begin
          if (ci_r == COUNT_LAST) begin
            if (long_new) begin
              dec  = 1'b1;
              code = OUT_LONG_CODE;
            end else if (st_over) begin
              dec  = 1'b1;
              code = OUT_BAD_DHT;
            end else if (st_new != '0) begin
              phase_nxt = PH_DHT_SYM;
            end else if (pr_dec == '0) begin
              seg_done  = 1'b1;
              phase_nxt = PH_PREFIX;
              dec       = lim_seg;
              code      = OUT_LIMIT;
            end else begin
              phase_nxt = PH_DHT_INFO;
            end
          end
        end
        PH_DHT_SYM: begin
          if (sk_dec == '0) begin
            if (pr_dec == '0) begin
              seg_done  = 1'b1;
              phase_nxt = PH_PREFIX;
              dec       = lim_seg;
              code      = OUT_LIMIT;
            end else begin
              phase_nxt = PH_DHT_INFO;
            end
          end
        end
        default: phase_nxt = ph;
      endcase
      if (!dec && it.last) begin
        dec  = 1'b1;
        code = OUT_DATA_ENDED;
      end
      if (dec) begin
        phase_nxt = PH_DONE;
      end
    end
  end

  // datapath updates
  always_comb begin
    pos_nxt    = pos_r;
    seg_nxt    = seg_r;
    pr_nxt     = pr_r;
    lh_nxt     = lh_r;
    mk_dht_nxt = mk_dht_r;
    ac_nxt     = ac_r;
    ci_nxt     = ci_r;
    st_nxt     = st_r;
    long_nxt   = long_r;
    sk_nxt     = sk_r;
    if (active) begin
      if (it.first) begin
        pr_nxt     = '0;
        lh_nxt     = '0;
        mk_dht_nxt = 1'b0;
        ac_nxt     = 1'b0;
        ci_nxt     = '0;
        st_nxt     = '0;
        long_nxt   = 1'b0;
        sk_nxt     = '0;
      end
      pos_nxt = off_inc;
      seg_nxt = seg_done ? off_inc : seg_base;
      case (ph)
        PH_MARKER: begin
          if (!it.cls.is_ff && !it.cls.is_stop && !it.cls.is_nolen) begin
            mk_dht_nxt = it.cls.is_dht;
          end
        end
        PH_LEN_HI: lh_nxt = it.data;
        PH_LEN_LO: begin
          if (!len_bad) begin
            pr_nxt = len_m2;
          end
        end
        PH_SKIP: pr_nxt = pr_dec;
        PH_DHT_INFO: begin
          pr_nxt = pr_dec;
          ac_nxt = it.data[DHT_AC_BIT];
          if (pr_dec >= DHT_COUNTS) begin
            ci_nxt   = '0;
            st_nxt   = '0;
            long_nxt = 1'b0;
          end
        end
        PH_DHT_COUNT: begin
          pr_nxt   = pr_dec;
          st_nxt   = st_new;
          long_nxt = long_new;
          if (ci_r != COUNT_LAST) begin
            ci_nxt = ci_r + 4'd1;
          end else begin
            sk_nxt = st_new;
          end
        end
        PH_DHT_SYM: begin
          pr_nxt = pr_dec;
          sk_nxt = sk_dec;
        end
        default: pr_nxt = pr_nxt;
      endcase
    end
  end

  assign res_push    = fire && dec;
  assign res_long    = (code == OUT_LONG_CODE);
  assign res_outcome = code;
  assign res_offset  = off;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_limit_r <= SCAN_LIMIT_RST;
      max_bits_r   <= MAX_BITS_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_SCAN_LIMIT:    scan_limit_r <= cfg_wdata[SCAN_LIMIT_W-1:0];
        CFG_MAX_CODE_BITS: max_bits_r   <= cfg_wdata[MAX_BITS_W-1:0];
        default:           scan_limit_r <= scan_limit_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_WAIT;
      pos_r    <= '0;
      seg_r    <= '0;
      pr_r     <= '0;
      lh_r     <= '0;
      mk_dht_r <= 1'b0;
      ac_r     <= 1'b0;
      ci_r     <= '0;
      st_r     <= '0;
      long_r   <= 1'b0;
      sk_r     <= '0;
    end else begin
      phase_r  <= phase_nxt;
      pos_r    <= pos_nxt;
      seg_r    <= seg_nxt;
      pr_r     <= pr_nxt;
      lh_r     <= lh_nxt;
      mk_dht_r <= mk_dht_nxt;
      ac_r     <= ac_nxt;
      ci_r     <= ci_nxt;
      st_r     <= st_nxt;
      long_r   <= long_nxt;
      sk_r     <= sk_nxt;
    end
  end

endmodule

>>> sv/jlahd_resq.sv
// Result queue: two-entry buffer between the back end and the result port.
// Depends on jlahd_pkg.
module jlahd_resq #(
  parameter int OFFSET_BITS = jlahd_pkg::OFFSET_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            push,
  input  logic                            long_in,
  input  logic [jlahd_pkg::OUTCOME_W-1:0] outcome_in,
  input  logic [OFFSET_BITS-1:0]          offset_in,
  output logic                            full,
  output logic                            empty,
  input  logic                            pop,
  output logic                            long_out,
  output logic [jlahd_pkg::OUTCOME_W-1:0] outcome_out,
  output logic [OFFSET_BITS-1:0]          offset_out
);
  import jlahd_pkg::*;

  localparam int RES_W = 1 + OUTCOME_W + OFFSET_BITS;
  localparam int PTR_W = $clog2(RES_Q_DEPTH);
  localparam int CNT_W = $clog2(RES_Q_DEPTH + 1);

  logic [RES_W-1:0] mem_r [RES_Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(RES_Q_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign {long_out, outcome_out, offset_out} = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + CNT_W'(do_push) - CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= {long_in, outcome_in, offset_in};
    end
  end

endmodule

>>> sv/jpeg_long_ac_huffman_detector.sv
// Top level of the JPEG long AC code detector: front queue, segment walker, result queue.
// Depends on jlahd_pkg, jlahd_front, jlahd_back, jlahd_resq.
//
//  port group | handshake        | payload
//  -----------+------------------+-----------------------------------------------
//  in_        | push / full      | data_byte, first_byte, last_byte
//  out_       | empty / pop      | long_code_found, outcome, byte_offset
//  cfg_       | we (no wait)     | index, wdata (scan_limit, max_code_bits)
//
// One byte a cycle unless stalled; the segment walker updates its state once per byte.
// A result shows on out_ once the walker has decided it and written it into the result queue.
// Reset (rst_n low at a clock edge) empties both queues and waits for a first byte.
// The walker stalls while the two-entry result queue is full; full rises once
// four bytes wait in the input queue.
module jpeg_long_ac_huffman_detector #(
  parameter int OFFSET_BITS = jlahd_pkg::OFFSET_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            push,
  output logic                            full,
  input  logic [7:0]                      in_data_byte,
  input  logic                            in_first_byte,
  input  logic                            in_last_byte,
  output logic                            empty,
  input  logic                            pop,
  output logic                            out_long_code_found,
  output logic [jlahd_pkg::OUTCOME_W-1:0] out_outcome,
  output logic [OFFSET_BITS-1:0]          out_byte_offset,
  input  logic                            cfg_we,
  input  logic [jlahd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [jlahd_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import jlahd_pkg::*;

  byte_item_t             q_item;
  logic                   q_valid, q_pop;
  logic                   res_full, res_push, res_long;
  logic [OUTCOME_W-1:0]   res_outcome;
  logic [OFFSET_BITS-1:0] res_offset;

  jlahd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .data_byte  (in_data_byte),
    .first_byte (in_first_byte),
    .last_byte  (in_last_byte),
    .full       (full),
    .q_pop      (q_pop),
    .q_valid    (q_valid),
    .q_item     (q_item)
  );

  jlahd_back #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop),
    .res_full    (res_full),
    .res_push    (res_push),
    .res_long    (res_long),
    .res_outcome (res_outcome),
    .res_offset  (res_offset)
  );

  jlahd_resq #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_resq (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (res_push),
    .long_in     (res_long),
    .outcome_in  (res_outcome),
    .offset_in   (res_offset),
    .full        (res_full),
    .empty       (empty),
    .pop         (pop),
    .long_out    (out_long_code_found),
    .outcome_out (out_outcome),
    .offset_out  (out_byte_offset)
  );

endmodule

>>> sv/jlahd_checker.sv
// Port-level checks for the JPEG long AC code detector, bound to the top level.
// Depends on jlahd_pkg and jpeg_long_ac_huffman_detector.
module jlahd_checker #(
  parameter int OFFSET_BITS = jlahd_pkg::OFFSET_BITS_DEF
) (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            full,
  input logic                            empty,
  input logic                            pop,
  input logic                            out_long_code_found,
  input logic [jlahd_pkg::OUTCOME_W-1:0] out_outcome,
  input logic [OFFSET_BITS-1:0]          out_byte_offset
);
  import jlahd_pkg::*;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> (empty && !full))
    else $error("queues not empty after reset");

  a_long_matches_outcome: assert property (@(posedge clk)
    !empty |-> (out_long_code_found == (out_outcome == OUT_LONG_CODE)))
    else $error("long_code_found disagrees with outcome");

  a_outcome_legal: assert property (@(posedge clk)
    !empty |-> (out_outcome <= OUT_LIMIT))
    else $error("outcome code out of range");

  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> !empty)
    else $error("waiting result dropped");

  a_offset_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> $stable(out_byte_offset))
    else $error("waiting result offset changed");

endmodule

bind jpeg_long_ac_huffman_detector jlahd_checker #(
  .OFFSET_BITS (OFFSET_BITS)
) u_jlahd_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .full                (full),
  .empty               (empty),
  .pop                 (pop),
  .out_long_code_found (out_long_code_found),
  .out_outcome         (out_outcome),
  .out_byte_offset     (out_byte_offset)
);

>>> verif/jpeg_long_ac_huffman_detector_tb.sv
// Self-checking testbench for jpeg_long_ac_huffman_detector: directed rows, then random JPEG-like
// files under several register settings, checked against a cycle-free marker-walk predictor.
// Depends on jlahd_pkg and the detector RTL.
module jpeg_long_ac_huffman_detector_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import jlahd_pkg::*;

  localparam int OFS_W       = OFFSET_BITS_DEF;
  localparam int STALL_LIMIT = 4000;
  localparam int PHASE_ITEMS = 150;

  typedef struct packed {
    logic [7:0]       data;
    logic             first;
    logic             last;
    logic             typed;
    logic             t_long;
    outcome_t         t_outcome;
    logic [OFS_W-1:0] t_offset;
  } stim_row_t;

  typedef struct packed {
    logic             long_code;
    outcome_t         outcome;
    logic [OFS_W-1:0] offset;
  } result_t;

  localparam stim_row_t DIRECTED [24] = '{
    '{8'h55,      1'b0, 1'b0, 1'b0, 1'b0, OUT_LONG_CODE,  20'd0},
    '{8'h00,      1'b1, 1'b0, 1'b1, 1'b0, OUT_BAD_SOI,    20'd0},
    '{MRK_PREFIX, 1'b1, 1'b0, 1'b0, 1'b0, OUT_LONG_CODE,  20'd0},
    '{8'h12,      1'b0, 1'b0, 1'b1, 1'b0, OUT_BAD_SOI,    20'd1},
    '{MRK_PREFIX, 1'b1, 1'b1, 1'b1, 1'b0, OUT_DATA_ENDED, 20'd0},
    '{MRK_PREFIX, 1'b1, 1'b0, 1'b0, 1'b0, OUT_LONG_CODE,  20'd0},
    '{MRK_SOI,    1'b0, 1'b1, 1'b1, 1'b0, OUT_DATA_ENDED, 20'd1},
    '{MRK_PREFIX, 1'b1, 1'b0, 1'b0, 1'b0, OUT_LONG_CODE,  20'd0},
    '{MRK_SOI,    1'b0, 1'b0, 1'b0, 1'b0, OUT_LONG_CODE,  20'd0},
    '{MRK_PREFIX, 1'b0, 1'b0, 1'b0, 1'b0, OUT_LONG_CODE,  20'd0},
    '{MRK_EOI,    1'b0, 1'b0, 1'b1, 1'b0, OUT_STOP,       20'd3},
    '{MRK_PREFIX, 1'b1, 1'b0, 1'b0, 1'b0, OUT_LONG_CODE,  20'd0},
    '{MRK_SOI,    1'b0, 1'b0, 1'b0, 1'b0, OUT_LONG_CODE,  20'd0},
    '{MRK_PREFIX, 1'b0, 1'b0, 1'b0, 1'b0, OUT_LONG_CODE,  20'd0},
    '{8'hE0,      1'b0, 1'b0, 1'b0, 1'b0, OUT_LONG_CODE,  20'd0},
    '{8'h00,      1'b0, 1'b0, 1'b0, 1'b0, OUT_LONG_CODE,  20'd0},
    '{8'h01,      1'b0, 1'b0, 1'b1, 1'b0, OUT_BAD_LENGTH, 20'd5},
    '{MRK_PREFIX, 1'b1, 1'b0, 1'b0, 1'b0, OUT_LONG_CODE,  20'd0},
    '{MRK_SOI,    1'b0, 1'b0, 1'b0, 1'b0, OUT_LONG_CODE,  20'd0},
    '{MRK_PREFIX, 1'b0, 1'b0, 1'b0, 1'b0, OUT_LONG_CODE,  20'd0},
    '{MRK_DHT,    1'b0, 1'b0, 1'b0, 1'b0, OUT_LONG_CODE,  20'd0},
    '{8'h00,      1'b0, 1'b0, 1'b0, 1'b0, OUT_LONG_CODE,  20'd0},
    '{8'h03,      1'b0, 1'b0, 1'b0, 1'b0, OUT_LONG_CODE,  20'd0},
    '{8'h10,      1'b0, 1'b0, 1'b1, 1'b0, OUT_BAD_DHT,    20'd6}
  };

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   push = 1'b0;
  logic                   full;
  logic [7:0]             in_data_byte = 8'h00;
  logic                   in_first_byte = 1'b0;
  logic                   in_last_byte = 1'b0;
  logic                   empty;
  logic                   pop = 1'b0;
  logic                   out_long_code_found;
  logic [OUTCOME_W-1:0]   out_outcome;
  logic [OFS_W-1:0]       out_byte_offset;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  jpeg_long_ac_huffman_detector #(.OFFSET_BITS(OFS_W)) dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .push                (push),
    .full                (full),
    .in_data_byte        (in_data_byte),
    .in_first_byte       (in_first_byte),
    .in_last_byte        (in_last_byte),
    .empty               (empty),
    .pop                 (pop),
    .out_long_code_found (out_long_code_found),
    .out_outcome         (out_outcome),
    .out_byte_offset     (out_byte_offset),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // walker model state and register copies
  logic [SCAN_LIMIT_W-1:0] lim_cfg = SCAN_LIMIT_RST;
  logic [MAX_BITS_W-1:0]   mcb_cfg = MAX_BITS_RST;
  phase_t                  ph = PH_WAIT;
  logic [OFS_W-1:0]        pos = '0;
  logic [OFS_W-1:0]        seg_end = '0;
  logic [15:0]             remaining = '0;
  logic [7:0]              len_hi = '0;
  logic [7:0]              marker = '0;
  logic                    tab_ac = 1'b0;
  logic [4:0]              cnt_idx = '0;
  logic [11:0]             sym_total = '0;
  logic [11:0]             sym_skip = '0;
  logic                    long_flag = 1'b0;
  logic                    w_hit = 1'b0;
  outcome_t                w_code = OUT_LONG_CODE;

  stim_row_t byte_stream[$];
  result_t   pending_results[$];
  stim_row_t drv_item = '0;
  logic      drv_valid = 1'b0;
  int        burst_left = 0;
  int        gap_left = 0;
  int        walked_items = 0;
  int        errors = 0;
  int        idle_cycles = 0;
  int        rx_tick = 0;
  logic [31:0] rx_pat = '1;

  task automatic flag_mismatch(input string what);
    if (errors < 50) $display("mismatch at %0t: %s", $realtime, what);
    errors++;
  endtask

  function automatic logic [OFS_W-1:0] next_off(input logic [OFS_W-1:0] x);
    return (x == '1) ? x : x + 1'b1;
  endfunction

  task automatic settle(input outcome_t c);
    w_hit = 1'b1;
    w_code = c;
    ph = PH_DONE;
  endtask

  task automatic loop_top();
    ph = PH_PREFIX;
    if (seg_end >= OFS_W'(lim_cfg)) settle(OUT_LIMIT);
  endtask

  task automatic seg_done(input logic [OFS_W-1:0] o);
    seg_end = next_off(o);
    loop_top();
  endtask

  task automatic table_done(input logic [OFS_W-1:0] o);
    if (remaining == 0) seg_done(o);
    else ph = PH_DHT_INFO;
  endtask

  task automatic walk_byte(input logic [7:0] b, input logic f, input logic l,
                           output logic hit, output outcome_t oc, output logic [OFS_W-1:0] at);
    logic [OFS_W-1:0] o;
    logic [15:0]      seglen;
    w_hit = 1'b0;
    w_code = OUT_LONG_CODE;
    hit = 1'b0;
    oc = OUT_LONG_CODE;
    at = '0;
    if (f) begin
      pos = '0;
      seg_end = '0;
      remaining = '0;
      len_hi = '0;
      marker = '0;
      tab_ac = 1'b0;
      cnt_idx = '0;
      sym_total = '0;
      sym_skip = '0;
      long_flag = 1'b0;
      ph = PH_SOI1;
    end
    if (ph == PH_WAIT || ph == PH_DONE) return;
    walked_items++;
    o = pos;
    case (ph)
      PH_SOI1: begin
        if (b != MRK_PREFIX) settle(OUT_BAD_SOI);
        else ph = PH_SOI2;
      end
      PH_SOI2: begin
        if (b != MRK_SOI) settle(OUT_BAD_SOI);
        else loop_top();
      end
      PH_PREFIX: begin
        if (b == MRK_PREFIX) ph = PH_MARKER;
        else loop_top();
      end
      PH_MARKER: begin
        if (b == MRK_PREFIX) begin
        end else if (b == MRK_SOS || b == MRK_EOI) begin
          settle(OUT_STOP);
        end else if (b == MRK_TEM || (b >= MRK_RST0 && b <= MRK_RST7)) begin
          loop_top();
        end else begin
          marker = b;
          ph = PH_LEN_HI;
        end
      end
      PH_LEN_HI: begin
        len_hi = b;
        ph = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        seglen = {len_hi, b};
        if (seglen < LEN_MIN) begin
          settle(OUT_BAD_LENGTH);
        end else begin
          remaining = seglen - LEN_MIN;
          if (remaining == 0) seg_done(o);
          else ph = (marker == MRK_DHT) ? PH_DHT_INFO : PH_SKIP;
        end
      end
      PH_SKIP: begin
        if (remaining != 0) remaining--;
        if (remaining == 0) seg_done(o);
      end
      PH_DHT_INFO: begin
        if (remaining != 0) remaining--;
        tab_ac = b[DHT_AC_BIT];
        if (remaining < DHT_COUNTS) begin
          settle(OUT_BAD_DHT);
        end else begin
          cnt_idx = '0;
          sym_total = '0;
          long_flag = 1'b0;
          ph = PH_DHT_COUNT;
        end
      end
      PH_DHT_COUNT: begin
        if (remaining != 0) remaining--;
        sym_total = sym_total + 12'(b);
        if (tab_ac && b != 0 && cnt_idx >= mcb_cfg) long_flag = 1'b1;
        if (cnt_idx >= COUNT_LAST) begin
          if (long_flag) begin
            settle(OUT_LONG_CODE);
          end else if (16'(sym_total) > remaining) begin
            settle(OUT_BAD_DHT);
          end else begin
            sym_skip = sym_total;
            if (sym_skip == 0) table_done(o);
            else ph = PH_DHT_SYM;
          end
        end else begin
          cnt_idx++;
        end
      end
      PH_DHT_SYM: begin
        if (remaining != 0) remaining--;
        if (sym_skip != 0) sym_skip--;
        if (sym_skip == 0) table_done(o);
      end
      default: begin
      end
    endcase
    if (!w_hit && l) settle(OUT_DATA_ENDED);
    pos = next_off(o);
    hit = w_hit;
    oc = w_code;
    at = o;
  endtask

  task automatic queue_byte(input logic [7:0] b, input logic f, input logic l);
    byte_stream.push_back('{b, f, l, 1'b0, 1'b0, OUT_LONG_CODE, '0});
  endtask

  task automatic build_file();
    logic [7:0] fb[$];
    logic [7:0] pl[$];
    logic [7:0] mk;
    logic [7:0] cnt;
    int         len;
    int         tot;
    int         kind;
    bit         do_last;
    fb = {};
    if ($urandom_range(0, 15) == 0) begin
      fb.push_back(8'($urandom));
    end else begin
      fb.push_back(MRK_PREFIX);
      fb.push_back(($urandom_range(0, 15) == 0) ? 8'($urandom) : MRK_SOI);
    end
    repeat ($urandom_range(0, 4)) begin
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        repeat ($urandom_range(1, 3)) fb.push_back(8'($urandom_range(0, 254)));
      end else if (kind == 1) begin
        fb.push_back(MRK_PREFIX);
        fb.push_back($urandom_range(0, 1) ? MRK_TEM : 8'(MRK_RST0 + $urandom_range(0, 7)));
      end else if (kind <= 4) begin
        mk = 8'($urandom_range(8'hC0, 8'hFE));
        if (mk == MRK_DHT || mk == MRK_SOS || mk == MRK_EOI || (mk >= MRK_RST0 && mk <= MRK_RST7))
          mk = 8'hE1;
        if ($urandom_range(0, 3) == 0) mk = 8'($urandom_range(0, 254));
        repeat ($urandom_range(0, 2)) fb.push_back(MRK_PREFIX);
        fb.push_back(MRK_PREFIX);
        fb.push_back(mk);
        len = $urandom_range(2, 8);
        if ($urandom_range(0, 19) == 0) len = $urandom_range(0, 1);
        if ($urandom_range(0, 19) == 0) len = $urandom_range(0, 65535);
        fb.push_back(8'(len >> 8));
        fb.push_back(8'(len));
        if (len > 2 && len < 16) repeat (len - 2) fb.push_back(8'($urandom));
      end else begin
        pl = {};
        repeat ($urandom_range(1, 2)) begin
          pl.push_back(8'($urandom));
          tot = 0;
          for (int i = 0; i < 16; i++) begin
            cnt = 8'd0;
            if ($urandom_range(0, (i < 8) ? 3 : 11) == 0) cnt = 8'($urandom_range(1, 2));
            tot += cnt;
            pl.push_back(cnt);
          end
          repeat (tot) pl.push_back(8'($urandom));
        end
        len = pl.size() + 2;
        if ($urandom_range(0, 9) == 0) len -= $urandom_range(1, 12);
        fb.push_back(MRK_PREFIX);
        fb.push_back(MRK_DHT);
        fb.push_back(8'(len >> 8));
        fb.push_back(8'(len));
        fb = {fb, pl};
      end
    end
    case ($urandom_range(0, 5))
      0, 1: begin
        fb.push_back(MRK_PREFIX);
        fb.push_back(MRK_EOI);
      end
      2, 3: begin
        fb.push_back(MRK_PREFIX);
        fb.push_back(MRK_SOS);
        repeat ($urandom_range(0, 2)) fb.push_back(8'($urandom));
      end
      4: begin
      end
      default: begin
        fb.push_back(MRK_PREFIX);
        fb.push_back(MRK_PREFIX);
        fb.push_back(MRK_SOS);
      end
    endcase
    if ($urandom_range(0, 5) == 0) fb[$urandom_range(0, fb.size() - 1)] = 8'($urandom);
    if ($urandom_range(0, 7) == 0) fb = fb[0:$urandom_range(0, fb.size() - 1)];
    do_last = ($urandom_range(0, 7) != 0);
    foreach (fb[i]) queue_byte(fb[i], i == 0, do_last && i == fb.size() - 1);
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3)) queue_byte(8'($urandom), 1'b0, 1'($urandom));
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == CFG_SCAN_LIMIT) lim_cfg = val[SCAN_LIMIT_W-1:0];
    else mcb_cfg = val[MAX_BITS_W-1:0];
  endtask

  task automatic wait_idle();
    while (byte_stream.size() != 0 || drv_valid || pending_results.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  // sender: bursts with random gaps; predict on every transfer
  always @(posedge clk) begin
    logic             hit;
    outcome_t         oc;
    logic [OFS_W-1:0] at;
    logic             nxt;
    if (push && !full) begin
      walk_byte(drv_item.data, drv_item.first, drv_item.last, hit, oc, at);
      if (drv_item.typed) begin
        if (!hit || oc != drv_item.t_outcome || at != drv_item.t_offset)
          flag_mismatch("walker model disagrees with directed row");
        pending_results.push_back('{drv_item.t_long, drv_item.t_outcome, drv_item.t_offset});
      end else if (hit) begin
        pending_results.push_back('{oc == OUT_LONG_CODE, oc, at});
      end
      drv_valid = 1'b0;
    end
    nxt = 1'b0;
    if (gap_left != 0) begin
      gap_left--;
    end else if (rst_n && (drv_valid || byte_stream.size() != 0)) begin
      if (!drv_valid) begin
        drv_item = byte_stream.pop_front();
        drv_valid = 1'b1;
      end
      nxt = 1'b1;
      burst_left--;
      if (burst_left <= 0) begin
        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 16);
        gap_left = $urandom_range(1, 8);
      end
    end
    push <= nxt;
    in_data_byte <= drv_item.data;
    in_first_byte <= drv_item.first;
    in_last_byte <= drv_item.last;
  end

  // receiver: check each transfer, stall on a rotating pattern
  always @(posedge clk) begin
    result_t e;
    if (pop && !empty) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("result with none expected");
      end else begin
        e = pending_results.pop_front();
        if (out_long_code_found !== e.long_code)
          flag_mismatch($sformatf("long_code_found %b, expected %b", out_long_code_found,
                                  e.long_code));
        if (out_outcome !== e.outcome)
          flag_mismatch($sformatf("outcome %0d, expected %0d", out_outcome, e.outcome));
        if (out_byte_offset !== e.offset)
          flag_mismatch($sformatf("byte_offset %0d, expected %0d", out_byte_offset, e.offset));
      end
    end
    if (rst_n) begin
      rx_tick++;
      if (rx_tick % 48 == 0) begin
        rx_pat = ($urandom_range(0, 3) == 0) ? '1 : $urandom;
        if (rx_pat == 0) rx_pat = 32'd1;
      end
      pop <= rx_pat[0];
      rx_pat = {rx_pat[0], rx_pat[31:1]};
    end
  end

  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) ||
        (byte_stream.size() == 0 && !drv_valid && pending_results.size() == 0)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    int                      goal;
    logic [SCAN_LIMIT_W-1:0] lim;
    logic [MAX_BITS_W-1:0]   mcb;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    foreach (DIRECTED[i]) byte_stream.push_back(DIRECTED[i]);
    wait_idle();
    for (int p = 1; p <= 8; p++) begin
      case (p)
        1: begin
          lim = '1;
          mcb = 5'd16;
        end
        2: begin
          lim = '0;
          mcb = 5'd1;
        end
        3, 6: begin
          lim = SCAN_LIMIT_W'($urandom_range(8, 120));
          mcb = MAX_BITS_W'($urandom_range(1, 16));
        end
        4: begin
          lim = '1;
          mcb = 5'd0;
        end
        5: begin
          lim = SCAN_LIMIT_W'($urandom_range(30, 300));
          mcb = 5'd31;
        end
        7: begin
          lim = SCAN_LIMIT_W'(1);
          mcb = MAX_BITS_W'($urandom_range(8, 15));
        end
        default: begin
          lim = SCAN_LIMIT_RST;
          mcb = MAX_BITS_RST;
        end
      endcase
      write_reg(CFG_SCAN_LIMIT, CFG_DATA_W'(lim));
      write_reg(CFG_MAX_CODE_BITS, CFG_DATA_W'(mcb));
      @(posedge clk);
      cfg_we <= 1'b0;
      goal = walked_items + PHASE_ITEMS;
      while (walked_items < goal) begin
        if (byte_stream.size() < 40) build_file();
        else @(posedge clk);
      end
      wait_idle();
    end
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
